>>> hw/rtl/ssym_pkg.sv
// Shared types, sizes and helpers for the scoped symbol table.
// Used by the controller, the datapath and the top level; depends on nothing.
package ssym_pkg;

   localparam int MAX_SYMBOLS = 256;
   localparam int MAX_DEPTH   = 16;
   localparam int NAME_BITS   = 16;

   localparam int KEY_IN_BITS    = 16;
   localparam int KIND_BITS      = 8;
   localparam int DEPTH_OUT_BITS = 4;
   localparam int SLOT_OUT_BITS  = 8;

   localparam int KEY_BITS   = (NAME_BITS < KEY_IN_BITS) ? NAME_BITS : KEY_IN_BITS;
   localparam int SLOT_BITS  = $clog2(MAX_SYMBOLS);
   localparam int COUNT_BITS = $clog2(MAX_SYMBOLS + 1);
   localparam int DEPTH_BITS = $clog2(MAX_DEPTH);

   typedef enum logic [1:0] {
      OP_OPEN   = 2'd0,
      OP_CLOSE  = 2'd1,
      OP_ADD    = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_STORE_FULL  = 2'd1,
      ST_STACK_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                 op;
      logic [KEY_IN_BITS-1:0] name_key;
      logic [KIND_BITS-1:0]   symbol_kind;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic                      found;
      logic [KIND_BITS-1:0]      found_kind;
      logic [DEPTH_OUT_BITS-1:0] found_depth;
      logic [SLOT_OUT_BITS-1:0]  found_slot;
      logic [DEPTH_OUT_BITS-1:0] current_depth;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPEN,
      S_CLOSE,
      S_ADD,
      S_LK_RD,
      S_LK_BOUND,
      S_LK_SCAN,
      S_LK_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;
      logic do_open;
      logic do_close;
      logic do_add;
      logic scan_rd;
      logic lk_bound;
      logic lk_issue;
      logic lk_advance;
      logic lk_finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_at_bound;
      logic depth_at_level;
   } stat_type;

   function automatic logic [DEPTH_OUT_BITS-1:0] depth_field(input logic [DEPTH_BITS-1:0] d);
      logic [63:0] w;
      w = 64'(d);
      return w[DEPTH_OUT_BITS-1:0];
   endfunction

   function automatic logic [SLOT_OUT_BITS-1:0] slot_field(input logic [SLOT_BITS-1:0] s);
      logic [63:0] w;
      w = 64'(s);
      return w[SLOT_OUT_BITS-1:0];
   endfunction

endpackage

>>> hw/rtl/ssym_ctrl.sv
// Sequencing state machine of the scoped symbol table.
// Depends on ssym_pkg; drives the command struct of ssym_dpath.
module ssym_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ssym_pkg::op_type  req_op,
   input  ssym_pkg::stat_type stat,
   output logic              busy,
   output ssym_pkg::cmd_type cmd
);

   ssym_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssym_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssym_pkg::S_IDLE: begin
            if (start) begin
               unique case (req_op)
                  ssym_pkg::OP_OPEN:   state_in = ssym_pkg::S_OPEN;
                  ssym_pkg::OP_CLOSE:  state_in = ssym_pkg::S_CLOSE;
                  ssym_pkg::OP_ADD:    state_in = ssym_pkg::S_ADD;
                  ssym_pkg::OP_LOOKUP: state_in = ssym_pkg::S_LK_RD;
                  default:             state_in = ssym_pkg::S_IDLE;
               endcase
            end
         end
         ssym_pkg::S_OPEN, ssym_pkg::S_CLOSE, ssym_pkg::S_ADD: begin
            state_in = ssym_pkg::S_IDLE;
         end
         ssym_pkg::S_LK_RD: begin
            state_in = ssym_pkg::S_LK_BOUND;
         end
         ssym_pkg::S_LK_BOUND: begin
            state_in = ssym_pkg::S_LK_SCAN;
         end
         ssym_pkg::S_LK_SCAN: begin
            if (stat.idx_at_bound) begin
               state_in = stat.depth_at_level ? ssym_pkg::S_LK_DONE : ssym_pkg::S_LK_RD;
            end
         end
         ssym_pkg::S_LK_DONE: begin
            state_in = ssym_pkg::S_IDLE;
         end
         default: begin
            state_in = ssym_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ssym_pkg::S_IDLE: begin
            busy          = 1'b0;
            cmd.latch_req = start;
         end
         ssym_pkg::S_OPEN:     cmd.do_open  = 1'b1;
         ssym_pkg::S_CLOSE:    cmd.do_close = 1'b1;
         ssym_pkg::S_ADD:      cmd.do_add   = 1'b1;
         ssym_pkg::S_LK_RD:    cmd.scan_rd  = 1'b1;
         ssym_pkg::S_LK_BOUND: cmd.lk_bound = 1'b1;
         ssym_pkg::S_LK_SCAN: begin
            cmd.lk_issue   = !stat.idx_at_bound;
            cmd.lk_advance = stat.idx_at_bound && !stat.depth_at_level;
         end
         ssym_pkg::S_LK_DONE:  cmd.lk_finish = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

>>> hw/rtl/ssym_dpath.sv
// Datapath of the scoped symbol table: symbol store, scope start stack,
// lookup scan with its compare stage, and the result register. Depends on ssym_pkg.
module ssym_dpath (
   input  logic               clock,
   input  logic               reset,
   input  ssym_pkg::req_type  req_data,
   input  ssym_pkg::cmd_type  cmd,
   output ssym_pkg::stat_type stat,
   output logic               rsp_valid,
   output ssym_pkg::rsp_type  rsp_data
);

   localparam int KB = ssym_pkg::KEY_BITS;
   localparam int SB = ssym_pkg::SLOT_BITS;
   localparam int CB = ssym_pkg::COUNT_BITS;
   localparam int DB = ssym_pkg::DEPTH_BITS;
   localparam int NB = ssym_pkg::KIND_BITS;

   // Memories.
   logic [KB-1:0] names_mem  [ssym_pkg::MAX_SYMBOLS];
   logic [NB-1:0] kinds_mem  [ssym_pkg::MAX_SYMBOLS];
   logic [CB-1:0] starts_mem [ssym_pkg::MAX_DEPTH];

   // Control state.
   logic [CB-1:0] count_ff, count_in;
   logic [DB-1:0] level_ff, level_in;
   logic          pend_ff, pend_in;
   logic          found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload state.
   ssym_pkg::req_type req_ff, req_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic [CB-1:0] bound_ff, bound_in;
   logic [DB-1:0] d_ff, d_in;
   logic [KB-1:0] name_rd_ff;
   logic [NB-1:0] kind_rd_ff;
   logic [CB-1:0] starts_rd_ff;
   logic [SB-1:0] pend_slot_ff, pend_slot_in;
   logic [DB-1:0] pend_depth_ff, pend_depth_in;
   logic [NB-1:0] best_kind_ff, best_kind_in;
   logic [DB-1:0] best_depth_ff, best_depth_in;
   logic [SB-1:0] best_slot_ff, best_slot_in;
   ssym_pkg::rsp_type rsp_ff, rsp_in;

   logic [KB-1:0] key;
   logic          stack_full;
   logic          store_full;
   logic [DB-1:0] level_inc;
   logic [DB-1:0] starts_raddr;
   logic          hit;

   assign key          = req_ff.name_key[KB-1:0];
   assign stack_full   = level_ff >= DB'(ssym_pkg::MAX_DEPTH - 1);
   assign store_full   = count_ff == CB'(ssym_pkg::MAX_SYMBOLS);
   assign level_inc    = level_ff + 1'b1;
   assign starts_raddr = cmd.scan_rd ? DB'(d_ff + 1'b1) : level_ff;
   assign hit          = pend_ff && (name_rd_ff == key)
                         && (!found_ff || pend_depth_ff > best_depth_ff);

   assign stat.idx_at_bound   = idx_ff >= bound_ff;
   assign stat.depth_at_level = d_ff == level_ff;

   always_comb begin
      count_in      = count_ff;
      level_in      = level_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      bound_in      = bound_ff;
      d_in          = d_ff;
      pend_in       = cmd.lk_issue;
      pend_slot_in  = pend_slot_ff;
      pend_depth_in = pend_depth_ff;
      found_in      = found_ff;
      best_kind_in  = best_kind_ff;
      best_depth_in = best_depth_ff;
      best_slot_in  = best_slot_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = cmd.do_open || cmd.do_close || cmd.do_add || cmd.lk_finish;

      if (cmd.latch_req) begin
         req_in   = req_data;
         idx_in   = '0;
         d_in     = '0;
         found_in = 1'b0;
      end else if (hit) begin
         found_in      = 1'b1;
         best_kind_in  = kind_rd_ff;
         best_depth_in = pend_depth_ff;
         best_slot_in  = pend_slot_ff;
      end

      if (cmd.lk_bound) begin
         bound_in = stat.depth_at_level ? count_ff : starts_rd_ff;
      end
      if (cmd.lk_issue) begin
         idx_in        = idx_ff + 1'b1;
         pend_slot_in  = idx_ff[SB-1:0];
         pend_depth_in = d_ff;
      end
      if (cmd.lk_advance) begin
         d_in = d_ff + 1'b1;
      end

      if (cmd.do_open) begin
         rsp_in = '0;
         if (stack_full) begin
            rsp_in.status        = ssym_pkg::ST_STACK_FULL;
            rsp_in.current_depth = ssym_pkg::depth_field(level_ff);
         end else begin
            level_in             = level_inc;
            rsp_in.status        = ssym_pkg::ST_OK;
            rsp_in.current_depth = ssym_pkg::depth_field(level_inc);
         end
      end

      if (cmd.do_close) begin
         rsp_in        = '0;
         rsp_in.status = ssym_pkg::ST_OK;
         if (level_ff != '0) begin
            count_in = starts_rd_ff;
            level_in = level_ff - 1'b1;
         end
         rsp_in.current_depth = ssym_pkg::depth_field(level_in);
      end

      if (cmd.do_add) begin
         rsp_in               = '0;
         rsp_in.current_depth = ssym_pkg::depth_field(level_ff);
         if (store_full) begin
            rsp_in.status = ssym_pkg::ST_STORE_FULL;
         end else begin
            rsp_in.status = ssym_pkg::ST_OK;
            count_in      = count_ff + 1'b1;
         end
      end

      if (cmd.lk_finish) begin
         rsp_in               = '0;
         rsp_in.status        = ssym_pkg::ST_OK;
         rsp_in.current_depth = ssym_pkg::depth_field(level_ff);
         if (found_ff) begin
            rsp_in.found       = 1'b1;
            rsp_in.found_kind  = best_kind_ff;
            rsp_in.found_depth = ssym_pkg::depth_field(best_depth_ff);
            rsp_in.found_slot  = ssym_pkg::slot_field(best_slot_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         level_ff     <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         level_ff     <= level_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      bound_ff      <= bound_in;
      d_ff          <= d_in;
      pend_slot_ff  <= pend_slot_in;
      pend_depth_ff <= pend_depth_in;
      best_kind_ff  <= best_kind_in;
      best_depth_ff <= best_depth_in;
      best_slot_ff  <= best_slot_in;
      rsp_ff        <= rsp_in;
   end

   // Symbol store: one write port for add, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (cmd.do_add && !store_full) begin
         names_mem[count_ff[SB-1:0]] <= key;
         kinds_mem[count_ff[SB-1:0]] <= req_ff.symbol_kind;
      end
      if (cmd.lk_issue) begin
         name_rd_ff <= names_mem[idx_ff[SB-1:0]];
         kind_rd_ff <= kinds_mem[idx_ff[SB-1:0]];
      end
   end

   // Scope start stack: written on open, read every cycle.
   always_ff @(posedge clock) begin
      if (cmd.do_open && !stack_full) begin
         starts_mem[level_inc] <= count_ff;
      end
      starts_rd_ff <= starts_mem[starts_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_issue_in_store: assert property (@(posedge clock) disable iff (reset)
      cmd.lk_issue |-> (idx_ff < count_ff) && (bound_ff <= count_ff))
      else $error("scan reads beyond the filled part of the store");

   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_add && !store_full) |=> count_ff == CB'($past(count_ff) + 1'b1))
      else $error("successful add did not advance the entry count");

   a_close_level: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_close && level_ff != '0) |=> level_ff == DB'($past(level_ff) - 1'b1))
      else $error("close of a nested scope did not drop one level");

   a_found_depth: assert property (@(posedge clock) disable iff (reset)
      (cmd.lk_finish && found_ff) |-> best_depth_ff <= level_ff)
      else $error("lookup match lies in a scope that is not open");

endmodule

>>> hw/rtl/scoped_symbol_table.sv
// Top level of the scoped symbol table: joins the controller and the datapath.
// Depends on ssym_pkg, ssym_ctrl and ssym_dpath.

// A command beat is taken on a rising edge where start is high and busy is low;
// each command returns exactly one result beat, shown for a single cycle with
// rsp_valid high, and the receiver cannot stall it, so it must capture the beat
// in that cycle. For open, close and add, busy is high while the command's own
// state runs, and the result appears in the cycle busy drops, when the next
// command may already be given. A lookup walks the symbol store one entry a
// cycle through its single read port, scope by scope from the root outward;
// for each open scope it first fetches that scope's boundary in S_LK_RD and
// S_LK_BOUND, then scans in S_LK_SCAN and leaves the scope once the index
// reaches the boundary, and busy stays high until S_LK_DONE gives the result.
// Within a scope the earliest added match wins, and a match in a deeper scope
// replaces one found further out. Closing the root scope is ignored and reports
// ok. An open that would exceed the scope stack reports stack full, and an add
// into a full store reports store full; neither changes any state. No clearing
// pass follows reset: the store and the scope stack are only used where written.
module scoped_symbol_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssym_pkg::req_type req_data,
   output logic              rsp_valid,
   output ssym_pkg::rsp_type rsp_data
);

   ssym_pkg::cmd_type  cmd;
   ssym_pkg::stat_type stat;

   // The controller sees only the opcode of the incoming beat.
   ssym_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   // The datapath latches the whole beat when the controller accepts it.
   ssym_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
